FILE: hw/rtl/set_associative_lru_cache_model_assert.svh
// ---------------------------------------------------------------------------
// set_associative_lru_cache_model_assert.svh
// Assertion macros for the cache model; all checks vanish under ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOCIATIVE_LRU_CACHE_MODEL_ASSERT_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_MODEL_ASSERT_SVH

`ifndef ASSERT_OFF
// general property, clocked on clk and disabled in reset
`define SLRU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// same-cycle implication
`define SLRU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SLRU_ASSERT(name, prop, msg)
`define SLRU_ASSERT_IMP(name, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/slru_pkg.sv
// ---------------------------------------------------------------------------
// slru_pkg
// Shared constants, codes, types and helpers of the set-associative cache.
// ---------------------------------------------------------------------------
package slru_pkg;

  // geometry
  localparam int MAX_SET_BITS    = 6;
  localparam int MAX_WAYS        = 8;
  localparam int MAX_OFFSET_BITS = 12;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << SET_W;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int SHIFT_W  = $clog2(MAX_SET_BITS + MAX_OFFSET_BITS + 1);

  // field widths
  localparam int ADDR_W = 64;
  localparam int TAG_W  = 64;
  localparam int OPC_W  = 2;
  localparam int OUTC_W = 2;
  localparam int TOT_W  = 32;
  localparam int SETB_W = 3;
  localparam int OFFB_W = 4;
  localparam int WAYS_W = 4;

  // config port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // access opcodes
  localparam logic [OPC_W-1:0] OP_IFETCH = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OPC_W-1:0] OP_STORE  = 2'd2;
  localparam logic [OPC_W-1:0] OP_MODIFY = 2'd3;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUT_IGNORED = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_HIT     = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_MISS    = 2'd2;
  localparam logic [OUTC_W-1:0] OUT_EVICT   = 2'd3;

  // register indexes
  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS        = 2'd2;

  typedef struct packed {
    logic [SETB_W-1:0] set_index_bits;
    logic [OFFB_W-1:0] offset_bits;
    logic [WAYS_W-1:0] ways_in_use;
  } cfg_t;

  // one set: valid bits, recency ranks and tags of all ways
  typedef struct packed {
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
  } row_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic              write_en;
    row_t              new_row;
  } upd_t;

  function automatic logic [SHIFT_W-1:0] eff_set_bits(input cfg_t c);
    if (32'(c.set_index_bits) > MAX_SET_BITS) return SHIFT_W'(MAX_SET_BITS);
    return SHIFT_W'(c.set_index_bits);
  endfunction

  function automatic logic [SHIFT_W-1:0] eff_offset_bits(input cfg_t c);
    if (32'(c.offset_bits) > MAX_OFFSET_BITS) return SHIFT_W'(MAX_OFFSET_BITS);
    return SHIFT_W'(c.offset_bits);
  endfunction

  function automatic logic [WCNT_W-1:0] eff_ways(input cfg_t c);
    if (c.ways_in_use == '0) return WCNT_W'(1);
    if (32'(c.ways_in_use) > MAX_WAYS) return WCNT_W'(MAX_WAYS);
    return WCNT_W'(c.ways_in_use);
  endfunction

  // saturating add of a small increment
  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] v,
                                               input logic [1:0] inc);
    logic [TOT_W:0] sum;
    sum = {1'b0, v} + (TOT_W + 1)'(inc);
    return sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/slru_if.sv
// ---------------------------------------------------------------------------
// slru_if
// Valid/ready channels for access words and result words.
// ---------------------------------------------------------------------------
interface slru_in_if import slru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [ADDR_W-1:0] access_address;

  modport source (output valid, output opcode, output access_address, input ready);
  modport sink   (input valid, input opcode, input access_address, output ready);
endinterface

interface slru_out_if import slru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OUTC_W-1:0] outcome;
  logic              second_hit;
  logic [TOT_W-1:0]  total_hits;
  logic [TOT_W-1:0]  total_misses;
  logic [TOT_W-1:0]  total_evictions;

  modport source (output valid, output outcome, output second_hit, output total_hits,
                  output total_misses, output total_evictions, input ready);
  modport sink   (input valid, input outcome, input second_hit, input total_hits,
                  input total_misses, input total_evictions, output ready);
endinterface

FILE: hw/rtl/slru_cfg.sv
// ---------------------------------------------------------------------------
// slru_cfg
// APB register file: set bits, offset bits and ways in use.
// ---------------------------------------------------------------------------
module slru_cfg import slru_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [SETB_W-1:0] set_index_bits_r;
  logic [OFFB_W-1:0] offset_bits_r;
  logic [WAYS_W-1:0] ways_in_use_r;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_index_bits_r <= SETB_W'(4);
      offset_bits_r    <= OFFB_W'(4);
      ways_in_use_r    <= WAYS_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_SET_BITS:    set_index_bits_r <= pwdata[SETB_W-1:0];
        REG_OFFSET_BITS: offset_bits_r    <= pwdata[OFFB_W-1:0];
        REG_WAYS:        ways_in_use_r    <= pwdata[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_SET_BITS:    prdata = CFG_DW'(set_index_bits_r);
      REG_OFFSET_BITS: prdata = CFG_DW'(offset_bits_r);
      REG_WAYS:        prdata = CFG_DW'(ways_in_use_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = '{set_index_bits: set_index_bits_r,
                   offset_bits:    offset_bits_r,
                   ways_in_use:    ways_in_use_r};

endmodule

FILE: hw/rtl/slru_upd.sv
// ---------------------------------------------------------------------------
// slru_upd
// Set update logic: tag match, fill or victim choice, LRU rank aging.
// ---------------------------------------------------------------------------
module slru_upd import slru_pkg::*; (
  input  row_t              row_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic [WCNT_W-1:0] ways_i,
  input  logic [OPC_W-1:0]  opcode_i,
  output upd_t              upd_o
);

  logic [MAX_WAYS-1:0] active;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] inv_vec;
  logic                hit_any;
  logic                inv_any;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    vic_way;
  logic [RANK_W-1:0]   vic_rank;
  logic [WAY_W-1:0]    sel_way;
  logic [WCNT_W-1:0]   old_rank;
  row_t                row_nxt;

  // per-way match and free flags
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      active[i]  = WCNT_W'(i) < ways_i;
      hit_vec[i] = active[i] && row_i.valid[i] && (row_i.tag[i] == tag_i);
      inv_vec[i] = active[i] && !row_i.valid[i];
    end
    hit_any = |hit_vec;
    inv_any = |inv_vec;
  end

  // lowest matching way and lowest free way
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_way = WAY_W'(i);
      if (inv_vec[i]) inv_way = WAY_W'(i);
    end
  end

  // oldest active way, ties to the lowest way
  always_comb begin
    vic_way  = '0;
    vic_rank = row_i.rank[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (active[i] && (row_i.rank[i] > vic_rank)) begin
        vic_way  = WAY_W'(i);
        vic_rank = row_i.rank[i];
      end
    end
  end

  // pick the way to touch and its old rank
  always_comb begin
    if (hit_any) begin
      sel_way  = hit_way;
      old_rank = WCNT_W'(row_i.rank[hit_way]);
    end else if (inv_any) begin
      sel_way  = inv_way;
      old_rank = WCNT_W'(MAX_WAYS);
    end else begin
      sel_way  = vic_way;
      old_rank = WCNT_W'(vic_rank);
    end
  end

  // age younger lines, make the touched line most recent, refill on miss
  always_comb begin
    row_nxt = row_i;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (active[i] && (WAY_W'(i) != sel_way) && row_i.valid[i] &&
          (WCNT_W'(row_i.rank[i]) < old_rank) &&
          (row_i.rank[i] != RANK_W'(MAX_WAYS - 1))) begin
        row_nxt.rank[i] = row_i.rank[i] + RANK_W'(1);
      end
    end
    row_nxt.rank[sel_way] = '0;
    if (!hit_any) begin
      row_nxt.valid[sel_way] = 1'b1;
      row_nxt.tag[sel_way]   = tag_i;
    end
  end

  // outcome
  always_comb begin
    upd_o.new_row = row_nxt;
    if (opcode_i == OP_IFETCH) begin
      upd_o.outcome  = OUT_IGNORED;
      upd_o.write_en = 1'b0;
    end else begin
      upd_o.write_en = 1'b1;
      if (hit_any)      upd_o.outcome = OUT_HIT;
      else if (inv_any) upd_o.outcome = OUT_MISS;
      else              upd_o.outcome = OUT_EVICT;
    end
  end

endmodule

FILE: hw/rtl/set_associative_lru_cache_model.sv
// ---------------------------------------------------------------------------
// set_associative_lru_cache_model
// Set-associative cache model with LRU replacement and saturating totals.
// ---------------------------------------------------------------------------
// In the accept cycle of an access word the set index and tag are split from
// the address and the whole set (valid bits, ranks and tags of all ways) is
// read from a single-port set memory; in the update state after it the set is
// matched, updated and written back, totals are bumped and the result word is
// loaded into the output register. The memory's read-then-write on its one
// port keeps a new access word out until the last has left the update state;
// a result word not taken holds the update state until the output register
// frees. A modify needs no second pass: its second access always hits the
// line just touched. No clearing pass is needed after reset: a flag per set
// marks sets never written, which read as empty. Configuration must be
// written over APB only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`include "set_associative_lru_cache_model_assert.svh"

module set_associative_lru_cache_model import slru_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  slru_in_if.sink           in_ch,
  slru_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  cfg_t              cfg;
  logic [SHIFT_W-1:0] sb;
  logic [SHIFT_W-1:0] ob;
  logic [WCNT_W-1:0] ways;
  logic [ADDR_W-1:0] off_shift;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  set_nxt;
  logic [TAG_W-1:0]  tag_nxt;

  logic              state_r;
  logic              state_nxt;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;
  logic [OPC_W-1:0]  opcode_r;
  row_t              rd_row_r;
  logic              row_ok_r;
  logic [NUM_SETS-1:0] row_wr_r;
  row_t              set_mem [NUM_SETS];
  row_t              cur_row;
  upd_t              upd;

  logic              accept;
  logic              out_free;
  logic              upd_fire;
  logic              mem_we;

  logic              out_valid_r;
  logic [OUTC_W-1:0] outcome_r;
  logic              second_hit_r;
  logic [TOT_W-1:0]  hit_total_r;
  logic [TOT_W-1:0]  miss_total_r;
  logic [TOT_W-1:0]  evict_total_r;
  logic [TOT_W-1:0]  hit_total_nxt;
  logic [TOT_W-1:0]  miss_total_nxt;
  logic [TOT_W-1:0]  evict_total_nxt;
  logic [1:0]        hit_inc;

  // configuration registers
  slru_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // address split
  always_comb begin
    sb        = eff_set_bits(cfg);
    ob        = eff_offset_bits(cfg);
    ways      = eff_ways(cfg);
    off_shift = in_ch.access_address >> ob;
    set_mask  = ~({SET_W{1'b1}} << sb);
    set_nxt   = off_shift[SET_W-1:0] & set_mask;
    tag_nxt   = in_ch.access_address >> (sb + ob);
  end

  // handshake
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign upd_fire    = (state_r == ST_UPD) && out_free;
  assign mem_we      = upd_fire && upd.write_en;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_UPD;
      ST_UPD:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // access word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      set_r    <= set_nxt;
      tag_r    <= tag_nxt;
      opcode_r <= in_ch.opcode;
    end
  end

  // set memory, read on accept and written back in the update cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row_r <= set_mem[set_nxt];
    end
    if (mem_we) begin
      set_mem[set_r] <= upd.new_row;
    end
  end

  // written-set flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_wr_r <= '0;
      row_ok_r <= 1'b0;
    end else begin
      if (accept) row_ok_r <= row_wr_r[set_nxt];
      if (mem_we) row_wr_r[set_r] <= 1'b1;
    end
  end

  // a set never written reads as empty
  always_comb begin
    cur_row = rd_row_r;
    if (!row_ok_r) begin
      cur_row.valid = '0;
      cur_row.rank  = '0;
    end
  end

  // match and update the set
  slru_upd u_upd (
    .row_i    (cur_row),
    .tag_i    (tag_r),
    .ways_i   (ways),
    .opcode_i (opcode_r),
    .upd_o    (upd)
  );

  // running totals
  always_comb begin
    hit_inc = {1'b0, upd.outcome == OUT_HIT} + {1'b0, opcode_r == OP_MODIFY};
    hit_total_nxt   = sat_add(hit_total_r, hit_inc);
    miss_total_nxt  = sat_add(miss_total_r,
                              {1'b0, upd.outcome == OUT_MISS || upd.outcome == OUT_EVICT});
    evict_total_nxt = sat_add(evict_total_r, {1'b0, upd.outcome == OUT_EVICT});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_total_r   <= '0;
      miss_total_r  <= '0;
      evict_total_r <= '0;
    end else if (upd_fire) begin
      hit_total_r   <= hit_total_nxt;
      miss_total_r  <= miss_total_nxt;
      evict_total_r <= evict_total_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      outcome_r    <= upd.outcome;
      second_hit_r <= (opcode_r == OP_MODIFY);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.outcome         = outcome_r;
  assign out_ch.second_hit      = second_hit_r;
  assign out_ch.total_hits      = hit_total_r;
  assign out_ch.total_misses    = miss_total_r;
  assign out_ch.total_evictions = evict_total_r;

  // checks
  `SLRU_ASSERT(a_accept_to_update, (in_ch.valid && in_ch.ready) |=> (state_r == ST_UPD), "accepted word did not reach update")
  `SLRU_ASSERT(a_update_done, (state_r == ST_UPD && out_free) |=> (state_r == ST_IDLE), "update cycle did not finish")
  `SLRU_ASSERT_IMP(a_second_hit_access, out_valid_r && second_hit_r, outcome_r != OUT_IGNORED, "second hit on ignored word")
  `SLRU_ASSERT(a_hits_monotonic, $past(rst_n) |-> (hit_total_r >= $past(hit_total_r)), "hit total went down")

endmodule
